FILE: src/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

    localparam int CHECK_BITS = 8;
    localparam int MAX_DATA   = 127;
    localparam int SYN_W      = CHECK_BITS - 1;
    localparam int LEN_W      = 7;
    localparam int POS_W      = 8;
    localparam int SYN_IDX_W  = $clog2(SYN_W);
    localparam int LOW_W      = 64;
    localparam int HIGH_W     = MAX_DATA - LOW_W;
    localparam int STATUS_W   = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_DATA);

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEAN        = 3'd0,
        ST_FIXED        = 3'd1,
        ST_PARITY_ERR   = 3'd2,
        ST_SYN_NO_PAR   = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } status_t;

    typedef struct packed {
        logic [MAX_DATA-1:0] data;
        logic [SYN_W-1:0]    syn;
        logic                pmis;
        logic [LEN_W-1:0]    len;
    } frame_t;

endpackage

FILE: src/psc_front.sv
`timescale 1ns / 1ps

module psc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        data_bit,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psc_pkg::LEN_W-1:0]   data_length,
    input  logic                        q_full,
    output logic                        q_push,
    output psc_pkg::frame_t             q_entry
);
    import psc_pkg::*;

    logic [LEN_W-1:0]     len_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [SYN_W-1:0]     syn_reg;
    logic [SYN_W-1:0]     syn_next;
    logic                 par_reg;
    logic                 par_next;
    logic [MAX_DATA-1:0]  store_reg;
    logic [MAX_DATA-1:0]  len_mask;
    logic [POS_W-1:0]     last_pos;
    logic [POS_W-1:0]     pos_plus;
    logic [POS_W-1:0]     check_off;
    logic                 accept;
    logic                 data_phase;
    logic                 check_phase;
    logic                 final_phase;

    assign cfg_ready   = 1'b1;
    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;

    assign last_pos    = POS_W'(len_reg) + POS_W'(SYN_W);
    assign pos_plus    = pos_reg + POS_W'(1);
    assign check_off   = pos_reg - POS_W'(len_reg);
    assign data_phase  = pos_reg < POS_W'(len_reg);
    assign check_phase = !data_phase && (pos_reg < last_pos);
    assign final_phase = !data_phase && !check_phase;

    always_comb
    begin
        for (int i = 0; i < MAX_DATA; i++)
        begin
            len_mask[i] = (i < int'(len_reg));
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        syn_next = syn_reg;
        par_next = par_reg;
        if (accept)
        begin
            if (data_phase)
            begin
                pos_next = pos_plus;
                if (data_bit)
                begin
                    syn_next = syn_reg ^ pos_plus[SYN_W-1:0];
                    par_next = !par_reg;
                end
            end
            else if (check_phase)
            begin
                pos_next = pos_plus;
                if (data_bit)
                begin
                    syn_next = syn_reg ^ (SYN_W'(1) << check_off[SYN_IDX_W-1:0]);
                end
            end
            else
            begin
                pos_next = '0;
                syn_next = '0;
                par_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            pos_reg <= '0;
            syn_reg <= '0;
            par_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= data_length;
            end
            pos_reg <= pos_next;
            syn_reg <= syn_next;
            par_reg <= par_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && data_phase)
        begin
            store_reg[pos_reg[LEN_W-1:0]] <= data_bit;
        end
    end

    assign q_push       = accept && final_phase;
    assign q_entry.data = store_reg & len_mask;
    assign q_entry.syn  = syn_reg;
    assign q_entry.pmis = par_reg ^ data_bit;
    assign q_entry.len  = len_reg;

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_DATA + SYN_W))
        else $error("Bit position ran past the end of the longest frame.");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (pos_reg == '0) && (syn_reg == '0) && !par_reg)
        else $error("Frame counters not cleared after the final bit.");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("Frame pushed into a full queue.");

endmodule

FILE: src/psc_queue.sv
`timescale 1ns / 1ps

module psc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psc_pkg::frame_t   push_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output psc_pkg::frame_t   q_entry
);
    import psc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue fill count exceeds its depth.");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("Queue popped while empty.");

    a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Empty queue with pointers apart.");

endmodule

FILE: src/psc_back.sv
`timescale 1ns / 1ps

module psc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  psc_pkg::frame_t                 q_entry,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [psc_pkg::LOW_W-1:0]       corrected_low,
    output logic [psc_pkg::HIGH_W-1:0]      corrected_high,
    output logic [psc_pkg::STATUS_W-1:0]    status,
    output logic [psc_pkg::LEN_W-1:0]       flipped_index
);
    import psc_pkg::*;

    logic                 out_valid_reg;
    logic [MAX_DATA-1:0]  data_reg;
    status_t              status_reg;
    logic [LEN_W-1:0]     flip_reg;

    status_t              status_next;
    logic [LEN_W-1:0]     flip_next;
    logic [MAX_DATA-1:0]  flip_vec;
    logic [LEN_W-1:0]     syn_idx;
    logic                 fix;
    logic                 syn_zero;
    logic                 syn_in_range;

    assign q_pop        = q_valid && (!out_valid_reg || out_ready);
    assign syn_zero     = (q_entry.syn == '0);
    assign syn_in_range = LEN_W'(q_entry.syn) <= q_entry.len;
    assign syn_idx      = LEN_W'(q_entry.syn) - LEN_W'(1);

    always_comb
    begin
        fix         = 1'b0;
        status_next = ST_CLEAN;
        if (q_entry.pmis)
        begin
            if (syn_zero)
            begin
                status_next = ST_PARITY_ERR;
            end
            else if (syn_in_range)
            begin
                status_next = ST_FIXED;
                fix         = 1'b1;
            end
            else
            begin
                status_next = ST_OUT_OF_RANGE;
            end
        end
        else if (!syn_zero)
        begin
            status_next = ST_SYN_NO_PAR;
        end
        flip_next = fix ? syn_idx : '0;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DATA; i++)
        begin
            flip_vec[i] = fix && (i == int'(syn_idx));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg   <= q_entry.data ^ flip_vec;
            status_reg <= status_next;
            flip_reg   <= flip_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign corrected_low  = data_reg[LOW_W-1:0];
    assign corrected_high = data_reg[MAX_DATA-1:LOW_W];
    assign status         = status_reg;
    assign flipped_index  = flip_reg;

    a_index_zero_unless_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg != ST_FIXED) |-> (flip_reg == '0))
        else $error("Flipped index set without a correction.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_reg) && $stable(flip_reg))
        else $error("Result changed while the receiver stalled.");

    a_pop_fix_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && fix |-> $onehot(flip_vec))
        else $error("Correction does not touch exactly one bit.");

endmodule

FILE: src/position_syndrome_corrector_top.sv
`timescale 1ns / 1ps

// Single-error corrector for a serial frame received one bit per input item.
// A frame is data_length data bits, then seven position-parity bits, then one
// parity bit over the data bits. The length is set through the configuration
// channel (cfg_valid, cfg_ready, data_length), which is always ready; it resets
// to 127. Bits enter on in_valid/in_ready/data_bit at one item per cycle while
// in_ready is high. After the parity bit one result leaves on out_valid and
// out_ready: the corrected data split over corrected_low and corrected_high, a
// status code and the flipped index. The final bit pushes the frame into the
// queue, and out_valid rises once the correction stage pops and registers it.
// No gap is needed between frames. The front collects bits into a register
// store, a small frame queue decouples it from the correction stage, and an
// output register holds the result. When the receiver stalls, results wait in
// the queue and in_ready drops only once the queue is full. Reset clears the
// bit counter, syndrome, parity, the queue and the output valid flag.
module position_syndrome_corrector_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psc_pkg::LEN_W-1:0]       data_length,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            data_bit,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [psc_pkg::LOW_W-1:0]       corrected_low,
    output logic [psc_pkg::HIGH_W-1:0]      corrected_high,
    output logic [psc_pkg::STATUS_W-1:0]    status,
    output logic [psc_pkg::LEN_W-1:0]       flipped_index
);
    import psc_pkg::*;

    frame_t push_entry;
    frame_t head_entry;
    logic   push;
    logic   full;
    logic   pop;
    logic   head_valid;

    psc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_bit    (data_bit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .data_length (data_length),
        .q_full      (full),
        .q_push      (push),
        .q_entry     (push_entry)
    );

    psc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .q_valid    (head_valid),
        .q_entry    (head_entry)
    );

    psc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (head_valid),
        .q_entry        (head_entry),
        .q_pop          (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .corrected_low  (corrected_low),
        .corrected_high (corrected_high),
        .status         (status),
        .flipped_index  (flipped_index)
    );

endmodule
